FILE: hdl/frame_difference_motion_detector_defines.svh
// assertion macros shared by the frame difference motion detector rtl
`ifndef FRAME_DIFFERENCE_MOTION_DETECTOR_DEFINES_SVH
`define FRAME_DIFFERENCE_MOTION_DETECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked on every clock edge outside reset
`define FDMD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every clock edge, reset included
`define FDMD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FDMD_ASSERT(lbl, clk, rst_n, prop, msg)
`define FDMD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hdl/fdmd_pkg.sv
// types and constants of the frame difference motion detector
`default_nettype none

package fdmd_pkg;

  localparam int MAX_PIXELS = 262144;
  localparam int PIXEL_BITS = 8;
  localparam int ADDR_W     = $clog2(MAX_PIXELS);
  localparam int LEN_W      = ADDR_W + 1;

  localparam int CFG_W   = 19;
  localparam int CNT_W   = 19;
  localparam int RUN_W   = 4;
  localparam int BAND_W  = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [RUN_W-1:0] RUN_MAX   = '1;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PIXELS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_FRAMES   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOST_FRAMES     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_LOW        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_HIGH       = 3'd5;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_DETECT = 2'd1,
    EV_LOST   = 2'd2
  } event_e;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  load_reference;
  } pix_in_t;

  typedef struct packed {
    event_e           event_res;
    logic             motion_active;
    logic [CNT_W-1:0] band_count;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0]  frame_pixels;
    logic [CNT_W-1:0]  count_threshold;
    logic [RUN_W-1:0]  detect_frames;
    logic [RUN_W-1:0]  lost_frames;
    logic [BAND_W-1:0] band_low;
    logic [BAND_W-1:0] band_high;
  } cfg_t;

  // one classified pixel as handed from front to back
  typedef struct packed {
    logic in_band;
    logic first;
    logic last;
    logic loading;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic              pop;
  } q_pop_t;

  typedef struct packed {
    logic              not_empty;
    logic [QCNT_W-1:0] count;
    q_entry_t          head;
  } q_status_t;

endpackage

`default_nettype wire

FILE: hdl/fdmd_ram.sv
// generic single write port ram with registered read
`default_nettype none

module fdmd_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read returns the contents before a write to the same address in this cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/fdmd_front.sv
// front: pixel position, frame store access and band classification
`default_nettype none

module fdmd_front
  import fdmd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire pix_in_t   in_data_i,
  input  wire q_status_t q_status_i,
  output q_push_t        q_push_o
);

  logic                  accept;
  logic [ADDR_W-1:0]     idx_q, idx_d;
  logic                  loading_q, loading_d;
  logic [LEN_W-1:0]      len;
  logic                  first, last, loading;

  logic                  s1_valid_q;
  logic [PIXEL_BITS-1:0] s1_pixel_q;
  logic                  s1_first_q, s1_last_q, s1_loading_q;

  logic [PIXEL_BITS-1:0] old_pixel;
  logic [PIXEL_BITS-1:0] diff;
  logic [QCNT_W:0]       in_flight;

  // frame length clamped to 1 .. MAX_PIXELS
  always_comb begin
    if (cfg_i.frame_pixels == '0) begin
      len = LEN_W'(1);
    end else if (32'(cfg_i.frame_pixels) > MAX_PIXELS) begin
      len = LEN_W'(MAX_PIXELS);
    end else begin
      len = LEN_W'(cfg_i.frame_pixels);
    end
  end

  // room for the queued items plus the one in the read stage
  assign in_flight  = (QCNT_W + 1)'(q_status_i.count) + (QCNT_W + 1)'(s1_valid_q);
  assign in_ready_o = in_flight < (QCNT_W + 1)'(QDEPTH);
  assign accept     = in_valid_i && in_ready_o;

  assign first   = (idx_q == '0);
  assign loading = first ? in_data_i.load_reference : loading_q;
  assign last    = (LEN_W'(idx_q) + LEN_W'(1)) >= len;

  always_comb begin
    idx_d     = idx_q;
    loading_d = loading_q;
    if (accept) begin
      idx_d     = last ? '0 : idx_q + ADDR_W'(1);
      loading_d = loading;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      loading_q  <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      idx_q      <= idx_d;
      loading_q  <= loading_d;
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pixel_q   <= in_data_i.pixel;
      s1_first_q   <= first;
      s1_last_q    <= last;
      s1_loading_q <= loading;
    end
  end

  // old value is read and the new one written at the same address
  fdmd_ram #(
    .Width (PIXEL_BITS),
    .Depth (MAX_PIXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (idx_q),
    .wdata_i (in_data_i.pixel),
    .re_i    (accept),
    .raddr_i (idx_q),
    .rdata_o (old_pixel)
  );

  assign diff = (s1_pixel_q >= old_pixel) ? (s1_pixel_q - old_pixel)
                                          : (old_pixel - s1_pixel_q);

  always_comb begin
    q_push_o.push          = s1_valid_q;
    q_push_o.entry.in_band = (diff >= cfg_i.band_low) && (diff <= cfg_i.band_high);
    q_push_o.entry.first   = s1_first_q;
    q_push_o.entry.last    = s1_last_q;
    q_push_o.entry.loading = s1_loading_q;
  end

endmodule

`default_nettype wire

FILE: hdl/fdmd_queue.sv
// short queue of classified pixels between front and back
`default_nettype none
`include "frame_difference_motion_detector_defines.svh"

module fdmd_queue
  import fdmd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire q_push_t push_i,
  input  wire q_pop_t  pop_i,
  output q_status_t    status_o
);

  q_entry_t          buf_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;

  always_comb begin
    count_d = count_q;
    case ({push_i.push, pop_i.pop})
      2'b10:   count_d = count_q + QCNT_W'(1);
      2'b01:   count_d = count_q - QCNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i.pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      buf_q[wr_ptr_q] <= push_i.entry;
    end
  end

  always_comb begin
    status_o.not_empty = (count_q != '0);
    status_o.count     = count_q;
    status_o.head      = buf_q[rd_ptr_q];
  end

  `FDMD_ASSERT(a_no_overflow, clk_i, rst_ni, push_i.push && !pop_i.pop |-> count_q != QCNT_W'(QDEPTH), "queue overflow")
  `FDMD_ASSERT(a_no_underflow, clk_i, rst_ni, pop_i.pop |-> count_q != '0, "queue underflow")
  `FDMD_ASSERT_ALWAYS(a_ptr_count, clk_i, (QPTR_W'(count_q) == QPTR_W'(wr_ptr_q - rd_ptr_q)) || !rst_ni, "queue pointers and count disagree")

endmodule

`default_nettype wire

FILE: hdl/fdmd_back.sv
// back: band count, frame decision, hysteresis and result register
`default_nettype none
`include "frame_difference_motion_detector_defines.svh"

module fdmd_back
  import fdmd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire q_status_t q_status_i,
  output q_pop_t         q_pop_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output result_t        out_data_o
);

  q_entry_t         head;
  logic             out_free;
  logic             makes_result;
  logic             pop;

  logic [CNT_W-1:0] count_q, count_base, count_new;
  logic [RUN_W-1:0] detect_run_q, detect_run_d;
  logic [RUN_W-1:0] lost_run_q, lost_run_d;
  logic             motion_q, motion_d;
  event_e           event_d;
  logic             out_valid_q, out_valid_d;
  result_t          out_q;

  assign head         = q_status_i.head;
  assign out_free     = !out_valid_q || out_ready_i;
  assign makes_result = head.last && !head.loading;
  assign pop          = q_status_i.not_empty && (!makes_result || out_free);
  assign q_pop_o.pop  = pop;

  assign count_base = head.first ? '0 : count_q;
  assign count_new  = (head.in_band && !head.loading && count_base != COUNT_MAX)
                      ? count_base + CNT_W'(1) : count_base;

  // frame decision and hysteresis
  always_comb begin
    detect_run_d = detect_run_q;
    lost_run_d   = lost_run_q;
    motion_d     = motion_q;
    event_d      = EV_NONE;
    if (count_new > cfg_i.count_threshold) begin
      if (!motion_q) begin
        if (detect_run_q != RUN_MAX) begin
          detect_run_d = detect_run_q + RUN_W'(1);
        end
        if (detect_run_d >= cfg_i.detect_frames) begin
          detect_run_d = '0;
          motion_d     = 1'b1;
          event_d      = EV_DETECT;
        end
      end
      lost_run_d = '0;
    end else begin
      if (motion_q) begin
        if (lost_run_q != RUN_MAX) begin
          lost_run_d = lost_run_q + RUN_W'(1);
        end
        if (lost_run_d >= cfg_i.lost_frames) begin
          lost_run_d = '0;
          motion_d   = 1'b0;
          event_d    = EV_LOST;
        end
      end
      detect_run_d = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop && makes_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      detect_run_q <= '0;
      lost_run_q   <= '0;
      motion_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop) begin
        count_q <= count_new;
      end
      if (pop && makes_result) begin
        detect_run_q <= detect_run_d;
        lost_run_q   <= lost_run_d;
        motion_q     <= motion_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && makes_result) begin
      out_q.event_res     <= event_d;
      out_q.motion_active <= motion_d;
      out_q.band_count    <= count_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `FDMD_ASSERT(a_detect_run_idle, clk_i, rst_ni, detect_run_q != '0 |-> !motion_q, "detect run counting while motion active")
  `FDMD_ASSERT(a_lost_run_active, clk_i, rst_ni, lost_run_q != '0 |-> motion_q, "lost run counting while no motion")
  `FDMD_ASSERT(a_event_state, clk_i, rst_ni, out_valid_q && out_q.event_res != EV_NONE |-> out_q.motion_active == (out_q.event_res == EV_DETECT), "event disagrees with motion state")

endmodule

`default_nettype wire

FILE: hdl/frame_difference_motion_detector.sv
// top level of the frame difference motion detector
//
// Grey pixels enter in raster order, one per transfer, and the block takes one pixel
// every clock cycle for as long as the result side keeps up. Each pixel reads the
// same position of the previous frame from a single frame store (MAX_PIXELS x 8 bit
// ram, one write and one registered read port) and overwrites it in the same cycle;
// that one store access per pixel is what sets the rate of one pixel per cycle. The
// absolute difference is checked against the inclusive band band_low..band_high and
// counted. At the last pixel of a frame the count is compared with count_threshold
// and the detect/lost hysteresis runs; one result transfer follows every compare
// frame, registered in the result register after its last pixel, while a frame whose first pixel
// carries load_reference only fills the store and gives no result. The store is not
// cleared after reset: the first frame after reset must be a load frame. Configuration
// registers are written through a plain write port and must only change while idle.
`default_nettype none

module frame_difference_motion_detector
  import fdmd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // pixel input channel
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire pix_in_t              in_data_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output result_t                   out_data_o,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i
);

  cfg_t      cfg_q;
  q_push_t   q_push;
  q_pop_t    q_pop;
  q_status_t q_status;

  // configuration registers, reset to the documented defaults
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_pixels    <= CFG_W'(262144);
      cfg_q.count_threshold <= CNT_W'(5);
      cfg_q.detect_frames   <= RUN_W'(2);
      cfg_q.lost_frames     <= RUN_W'(6);
      cfg_q.band_low        <= BAND_W'(86);
      cfg_q.band_high       <= BAND_W'(170);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_PIXELS:    cfg_q.frame_pixels    <= cfg_wdata_i[CFG_W-1:0];
        CFG_COUNT_THRESHOLD: cfg_q.count_threshold <= cfg_wdata_i[CNT_W-1:0];
        CFG_DETECT_FRAMES:   cfg_q.detect_frames   <= cfg_wdata_i[RUN_W-1:0];
        CFG_LOST_FRAMES:     cfg_q.lost_frames     <= cfg_wdata_i[RUN_W-1:0];
        CFG_BAND_LOW:        cfg_q.band_low        <= cfg_wdata_i[BAND_W-1:0];
        CFG_BAND_HIGH:       cfg_q.band_high       <= cfg_wdata_i[BAND_W-1:0];
        default:             cfg_q <= cfg_q;  // unused indexes are ignored
      endcase
    end
  end

  // front: pixel position, store read-modify-write, band classification
  fdmd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .q_push_o   (q_push)
  );

  // decouples the pixel side from result stalls; the front holds off when full
  fdmd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .pop_i    (q_pop),
    .status_o (q_status)
  );

  // back: counting, per-frame decision, hysteresis, result register
  fdmd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_status_i  (q_status),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: verif/motion_result_checker.sv
// result predictor and scoreboard for the frame difference motion detector
module motion_result_checker
  import fdmd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_ready_i,
  input  wire pix_in_t              in_data_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_ready_i,
  input  wire result_t              out_data_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  output int                        mismatches_o,
  output int                        awaited_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [PIXEL_BITS-1:0] prior_frame [MAX_PIXELS];
  int unsigned           pix_pos;
  logic [CNT_W-1:0]      hits;
  logic [RUN_W-1:0]      motion_streak;
  logic [RUN_W-1:0]      calm_streak;
  logic                  active;
  logic                  ref_load;
  cfg_t                  regs;
  result_t               results_due[$];
  int                    errs = 0;

  function automatic int unsigned frame_len();
    if (regs.frame_pixels == '0) return 1;
    if (regs.frame_pixels > MAX_PIXELS) return MAX_PIXELS;
    return regs.frame_pixels;
  endfunction

  // zero run length behaves as one
  function automatic logic [RUN_W-1:0] run_need(input logic [RUN_W-1:0] n);
    return (n == '0) ? 4'd1 : n;
  endfunction

  task automatic report_fault(input string what);
    errs++;
    if (errs <= 10) $display("%0t: %s", $time, what);
  endtask

  task automatic absorb_pixel(input pix_in_t p);
    logic [PIXEL_BITS-1:0] old;
    logic [PIXEL_BITS-1:0] diff;
    result_t               r;
    if (pix_pos == 0) begin
      ref_load = p.load_reference;
      hits = '0;
    end
    if (!ref_load) begin
      old  = prior_frame[pix_pos];
      diff = (p.pixel >= old) ? p.pixel - old : old - p.pixel;
      if (diff >= regs.band_low && diff <= regs.band_high && hits != COUNT_MAX) hits++;
    end
    prior_frame[pix_pos] = p.pixel;
    if (pix_pos + 1 < frame_len()) begin
      pix_pos++;
    end else begin
      pix_pos = 0;
      if (!ref_load) begin
        r.event_res = EV_NONE;
        if (hits > regs.count_threshold) begin
          if (!active) begin
            if (motion_streak != RUN_MAX) motion_streak++;
            if (motion_streak >= run_need(regs.detect_frames)) begin
              motion_streak = '0;
              active = 1'b1;
              r.event_res = EV_DETECT;
            end
          end
          calm_streak = '0;
        end else begin
          if (active) begin
            if (calm_streak != RUN_MAX) calm_streak++;
            if (calm_streak >= run_need(regs.lost_frames)) begin
              calm_streak = '0;
              active = 1'b0;
              r.event_res = EV_LOST;
            end
          end
          motion_streak = '0;
        end
        r.motion_active = active;
        r.band_count    = hits;
        results_due.push_back(r);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      pix_pos               = 0;
      hits                  = '0;
      motion_streak         = '0;
      calm_streak           = '0;
      active                = 1'b0;
      ref_load              = 1'b0;
      regs.frame_pixels     = 19'd262144;
      regs.count_threshold  = 19'd5;
      regs.detect_frames    = 4'd2;
      regs.lost_frames      = 4'd6;
      regs.band_low         = 8'd86;
      regs.band_high        = 8'd170;
      results_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FRAME_PIXELS:    regs.frame_pixels    = cfg_wdata_i;
          CFG_COUNT_THRESHOLD: regs.count_threshold = cfg_wdata_i;
          CFG_DETECT_FRAMES:   regs.detect_frames   = cfg_wdata_i[RUN_W-1:0];
          CFG_LOST_FRAMES:     regs.lost_frames     = cfg_wdata_i[RUN_W-1:0];
          CFG_BAND_LOW:        regs.band_low        = cfg_wdata_i[BAND_W-1:0];
          CFG_BAND_HIGH:       regs.band_high       = cfg_wdata_i[BAND_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          report_fault($sformatf("unexpected result ev=%0d act=%0d cnt=%0d",
                                 out_data_i.event_res, out_data_i.motion_active,
                                 out_data_i.band_count));
        end else begin
          exp_r = results_due.pop_front();
          if (out_data_i.event_res !== exp_r.event_res ||
              out_data_i.motion_active !== exp_r.motion_active ||
              out_data_i.band_count !== exp_r.band_count) begin
            report_fault($sformatf("result mismatch exp ev=%0d act=%0d cnt=%0d, got ev=%0d act=%0d cnt=%0d",
                                   exp_r.event_res, exp_r.motion_active, exp_r.band_count,
                                   out_data_i.event_res, out_data_i.motion_active,
                                   out_data_i.band_count));
          end
        end
      end
      if (in_valid_i && in_ready_i) absorb_pixel(in_data_i);
    end
    mismatches_o = errs;
    awaited_o    = results_due.size();
  end

endmodule

FILE: verif/frame_difference_motion_detector_test.sv
// stimulus, clocking and verdict for the frame difference motion detector
module frame_difference_motion_detector_test;
  import fdmd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles to let the back end settle after the last expected result
  localparam int SETTLE   = 16;
  // hard stop far past the slowest legal run (every item with long gaps and stalls)
  localparam int LIMIT_NS = 2_000_000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid;
  logic                 in_ready;
  pix_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  result_t              out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  int                   mismatches;
  int                   awaited;

  // stimulus-side view of the frame: position, written extent, last values sent
  int                    pos;
  int                    extent;
  int                    cur_len;
  int                    band_lo;
  int                    band_hi;
  logic [PIXEL_BITS-1:0] scene [256];
  bit                    moving;
  bit                    load_now;
  bit                    src_jitter;
  bit                    sink_jitter;
  int                    stall_left;

  frame_difference_motion_detector uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  motion_result_checker scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .mismatches_o (mismatches),
    .awaited_o    (awaited)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  // pixel for the current position, shaped by the frame mood
  function automatic logic [PIXEL_BITS-1:0] pick_pixel();
    int d;
    int base;
    if (load_now || pos >= 256) return 8'($urandom_range(0, 255));
    base = scene[pos];
    if (moving) begin
      // push the difference into the band most of the time
      if (band_lo <= band_hi && $urandom_range(0, 3) != 0) begin
        d = $urandom_range(band_lo, band_hi);
        if (base + d <= 255) return 8'(base + d);
        if (base >= d) return 8'(base - d);
      end
      return 8'($urandom_range(0, 255));
    end
    // still scene with a little noise
    return ($urandom_range(0, 7) != 0) ? 8'(base) : 8'($urandom_range(0, 255));
  endfunction

  // config write, with a shadow of what the stimulus needs to know
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    logic [CFG_W-1:0] v;
    v = value[CFG_W-1:0];
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = v;
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      CFG_FRAME_PIXELS: cur_len = (v == 0) ? 1 : (v > MAX_PIXELS) ? MAX_PIXELS : int'(v);
      CFG_BAND_LOW:     band_lo = v[BAND_W-1:0];
      CFG_BAND_HIGH:    band_hi = v[BAND_W-1:0];
      default: ;
    endcase
  endtask

  // one pixel transfer, valid held until accepted, then dropped
  task automatic feed(input logic [PIXEL_BITS-1:0] pix, input logic load, input int gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid               = 1'b1;
    in_data.pixel          = pix;
    in_data.load_reference = load;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
    in_valid = 1'b0;
    if (pos < 256) scene[pos] = pix;
    if (pos + 1 > extent) extent = pos + 1;
    pos = (pos + 1 >= cur_len) ? 0 : pos + 1;
  endtask

  // block idle: every result in, then a SETTLE wait for a trailing load frame
  task automatic drain();
    while (awaited != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // result side: ready with random stalls while jitter is on
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if (sink_jitter && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("frame_difference_motion_detector_test: done, errors");
    $finish;
  end

  initial begin
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_FRAME_PIXELS;
    cfg_wdata   = '0;
    pos         = 0;
    extent      = 0;
    cur_len     = MAX_PIXELS;
    band_lo     = 86;
    band_hi     = 170;
    moving      = 1'b0;
    load_now    = 1'b0;
    src_jitter  = 1'b0;
    sink_jitter = 1'b0;
    rst_ni      = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // oversized frame length is held to the maximum; a load frame under it
    // fills the start of the store past every later frame length
    write_reg(CFG_FRAME_PIXELS, 19'h7FFFF);
    repeat (64) begin
      feed(8'($urandom_range(0, 255)),
           (pos == 0) ? 1'b1 : 1'($urandom_range(0, 1)), 0);
    end
    drain();
    // shorter length lands inside the load frame, which ends at the next pixel
    write_reg(CFG_FRAME_PIXELS, 0);
    feed(8'd7, 1'b0, 0);     // end of the load frame, no result
    drain();

    // single pixel frames: zero length acts as one, zero runs act as one, full band
    write_reg(CFG_FRAME_PIXELS, 0);
    write_reg(CFG_COUNT_THRESHOLD, 0);
    write_reg(CFG_DETECT_FRAMES, 0);
    write_reg(CFG_LOST_FRAMES, 0);
    write_reg(CFG_BAND_LOW, 0);
    write_reg(CFG_BAND_HIGH, 255);
    feed(8'd255, 1'b1, 0);   // load frame, no result
    feed(8'd0, 1'b0, 0);     // largest difference, motion detected at once
    feed(8'd0, 1'b0, 0);     // zero difference still in band, motion while active
    drain();

    // band of a single value at the top
    write_reg(CFG_BAND_LOW, 255);
    write_reg(CFG_BAND_HIGH, 255);
    feed(8'd255, 1'b0, 0);   // counted, stays active
    feed(8'd255, 1'b0, 0);   // quiet, motion lost after one frame
    drain();

    // inverted band counts nothing, long runs, threshold at MAX_PIXELS
    write_reg(CFG_BAND_LOW, 200);
    write_reg(CFG_BAND_HIGH, 100);
    write_reg(CFG_DETECT_FRAMES, 15);
    write_reg(CFG_LOST_FRAMES, 15);
    write_reg(CFG_COUNT_THRESHOLD, 262144);
    feed(8'd0, 1'b0, 0);
    feed(8'd255, 1'b0, 0);
    drain();

    // two pixel frames around the band edges at default band
    write_reg(CFG_FRAME_PIXELS, 1);
    write_reg(CFG_FRAME_PIXELS, 2);
    write_reg(CFG_COUNT_THRESHOLD, 1);
    write_reg(CFG_DETECT_FRAMES, 2);
    write_reg(CFG_LOST_FRAMES, 1);
    write_reg(CFG_BAND_LOW, 86);
    write_reg(CFG_BAND_HIGH, 170);
    feed(8'd0, 1'b1, 0);
    feed(8'd0, 1'b0, 0);     // load frame of zeros
    feed(8'd86, 1'b0, 0);
    feed(8'd171, 1'b0, 0);   // lower edge in, upper edge plus one out: not above threshold
    feed(8'd0, 1'b0, 0);
    feed(8'd1, 1'b0, 0);     // differences at both edges: first motion frame
    feed(8'd170, 1'b0, 0);
    feed(8'd171, 1'b0, 0);   // second motion frame, motion detected
    feed(8'd170, 1'b0, 0);
    feed(8'd171, 1'b0, 0);   // still frame, motion lost
    drain();

    // random phases; a phase may end mid-frame so the next length change
    // lands inside a frame
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case ($urandom_range(0, 9))
        0:       write_reg(CFG_FRAME_PIXELS, 0);
        1:       write_reg(CFG_FRAME_PIXELS, 1);
        default: write_reg(CFG_FRAME_PIXELS, $urandom_range(2, 24));
      endcase
      write_reg(CFG_COUNT_THRESHOLD, ($urandom_range(0, 7) == 0) ?
                $urandom_range(0, 262144) : $urandom_range(0, cur_len / 2));
      write_reg(CFG_DETECT_FRAMES, ($urandom_range(0, 3) == 0) ?
                $urandom_range(0, 15) : $urandom_range(1, 3));
      write_reg(CFG_LOST_FRAMES, ($urandom_range(0, 3) == 0) ?
                $urandom_range(0, 15) : $urandom_range(1, 3));
      if ($urandom_range(0, 5) == 0) begin
        // inverted band
        write_reg(CFG_BAND_LOW, $urandom_range(1, 255));
        write_reg(CFG_BAND_HIGH, $urandom_range(0, band_lo - 1));
      end else begin
        write_reg(CFG_BAND_LOW, $urandom_range(0, 200));
        write_reg(CFG_BAND_HIGH, $urandom_range(band_lo, 255));
      end
      // some phases run with no idling at all on one or both sides
      src_jitter  = ($urandom_range(0, 3) != 0);
      sink_jitter = ($urandom_range(0, 3) != 0);
      repeat (128) begin
        // sender holds off until the result side has caught up
        if ($urandom_range(0, 49) == 0) begin
          while (awaited != 0) @(negedge clk_i);
        end
        if (pos == 0) begin
          load_now = (extent < cur_len) || ($urandom_range(0, 11) == 0);
          if ($urandom_range(0, 3) == 0) moving = !moving;
        end
        feed(pick_pixel(), (pos == 0) ? load_now : 1'($urandom_range(0, 1)),
             (src_jitter && $urandom_range(0, 2) == 0) ? pick_gap() : 0);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("frame_difference_motion_detector_test: done, clean");
    end else begin
      $display("frame_difference_motion_detector_test: done, errors");
    end
    $finish;
  end

endmodule
